// File: hdl/vscp_pkg.sv
// vscp_pkg: shared types, opcode and code constants for the sprite command parser
// used by vscp_ctrl, vscp_dpath and vector_sprite_command_parser_core
// no dependencies
package vscp_pkg;

  // opcodes
  localparam logic [7:0] OP_END       = 8'd0;
  localparam logic [7:0] OP_COLOR     = 8'd1;
  localparam logic [7:0] OP_DITHER    = 8'd2;
  localparam logic [7:0] OP_THICK     = 8'd3;
  localparam logic [7:0] OP_XFORM_ON  = 8'd5;
  localparam logic [7:0] OP_XFORM_OFF = 8'd6;
  localparam logic [7:0] OP_SHIFT     = 8'd7;
  localparam logic [7:0] OP_POINT     = 8'd8;
  localparam logic [7:0] OP_LINE      = 8'd10;
  localparam logic [7:0] OP_RECT      = 8'd12;
  localparam logic [7:0] OP_CIRCLE    = 8'd14;
  localparam logic [7:0] OP_FILL_A    = 8'd21;
  localparam logic [7:0] OP_FILL_B    = 8'd22;
  localparam logic [7:0] OP_ARROW     = 8'd26;

  // command lengths in bytes, opcode included
  localparam logic [4:0] LEN_UNKNOWN = 5'd0;
  localparam logic [4:0] LEN_SINGLE  = 5'd1;
  localparam logic [4:0] LEN_COLOR   = 5'd2;
  localparam logic [4:0] LEN_DITHER  = 5'd3;
  localparam logic [4:0] LEN_THICK   = 5'd5;
  localparam logic [4:0] LEN_POINT   = 5'd9;
  localparam logic [4:0] LEN_CIRCLE  = 5'd13;
  localparam logic [4:0] LEN_LONG    = 5'd17;

  // result kinds
  localparam logic [2:0] KIND_PIXEL  = 3'd0;
  localparam logic [2:0] KIND_LINE   = 3'd1;
  localparam logic [2:0] KIND_RECT   = 3'd2;
  localparam logic [2:0] KIND_CIRCLE = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  // stop reasons
  localparam logic [2:0] RSN_END       = 3'd0;
  localparam logic [2:0] RSN_TRUNC     = 3'd1;
  localparam logic [2:0] RSN_UNKNOWN   = 3'd2;
  localparam logic [2:0] RSN_OP_LIMIT  = 3'd3;
  localparam logic [2:0] RSN_EXHAUSTED = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 1'b1;

  localparam logic [3:0] COLOR_WHITE = 4'd15;
  localparam logic [2:0] THICK_RESET = 3'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_last;
  } in_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic [3:0]         color;
    logic [2:0]         stop_reason;
    logic               run_last;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic anch;
    logic diff;
    logic hor;
    logic draw_fire;
    logic done_fire;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic dec_draw;
    logic dec_done;
    logic is_line;
    logic pend_done;
    logic last_stroke;
    logic out_free;
  } sts_t;

  function automatic logic [4:0] cmd_len(input logic [7:0] op);
    logic [4:0] len;
    unique case (op)
      OP_END, OP_XFORM_ON, OP_XFORM_OFF:        len = LEN_SINGLE;
      OP_COLOR:                                 len = LEN_COLOR;
      OP_DITHER:                                len = LEN_DITHER;
      OP_THICK:                                 len = LEN_THICK;
      OP_SHIFT, OP_POINT, OP_FILL_A, OP_FILL_B: len = LEN_POINT;
      OP_LINE, OP_RECT, OP_ARROW:               len = LEN_LONG;
      OP_CIRCLE:                                len = LEN_CIRCLE;
      default:                                  len = LEN_UNKNOWN;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/vscp_ctrl.sv
// vscp_ctrl: sequencing state machine of the sprite command parser
// depends on vscp_pkg (ctl_t, sts_t)
module vscp_ctrl
  import vscp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  typedef enum logic [5:0] {
    ST_IN   = 6'b000001,
    ST_ANCH = 6'b000010,
    ST_DIFF = 6'b000100,
    ST_HOR  = 6'b001000,
    ST_DRAW = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e st_q, st_d;
  logic   draw_end;

  assign in_ready_o = (st_q == ST_IN);
  assign draw_end   = !sts_i.is_line || sts_i.last_stroke;

  always_comb begin
    st_d  = st_q;
    ctl_o = '0;
    unique case (st_q)
      ST_IN: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          if (sts_i.dec_draw) begin
            st_d = ST_ANCH;
          end else if (sts_i.dec_done) begin
            st_d = ST_DONE;
          end
        end
      end
      ST_ANCH: begin
        ctl_o.anch = 1'b1;
        st_d = sts_i.is_line ? ST_DIFF : ST_DRAW;
      end
      ST_DIFF: begin
        ctl_o.diff = 1'b1;
        st_d = ST_HOR;
      end
      ST_HOR: begin
        ctl_o.hor = 1'b1;
        st_d = ST_DRAW;
      end
      ST_DRAW: begin
        if (sts_i.out_free) begin
          ctl_o.draw_fire = 1'b1;
          if (draw_end) begin
            st_d = sts_i.pend_done ? ST_DONE : ST_IN;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.done_fire = 1'b1;
          st_d = ST_IN;
        end
      end
      default: st_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IN;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: hdl/vscp_dpath.sv
// vscp_dpath: parse state, operand store, anchor registers, stroke expansion
// and the output register of the sprite command parser
// depends on vscp_pkg
module vscp_dpath
  import vscp_pkg::*;
#(
  parameter int MAX_OPS   = 200,
  parameter int MAX_THICK = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_t                  in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  ctl_t                 ctl_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  // stream parse state
  logic [7:0]  opc_q, opc_n;
  logic [4:0]  idx_q, idx_n;
  logic [7:0]  ops_q, ops_n;
  logic [3:0]  color_q, color_n;
  logic [2:0]  thick_q, thick_n;
  logic        stopped_q;
  logic [7:0]  opnd_q [16];

  logic [31:0] anchor_x_q, anchor_y_q;

  // per-byte emission context
  logic [2:0]  kind_q, kind_n;
  logic        is_line_q;
  logic        done_pend_q;
  logic [2:0]  reason_q;
  logic [3:0]  em_color_q;
  logic [2:0]  em_thick_q;

  // draw arithmetic
  logic [31:0] x1_q, y1_q, x2_q, y2_q;
  logic [32:0] dx_q, dy_q;
  logic        horiz_q;
  logic [2:0]  stroke_q;

  logic        out_valid_q;
  out_t        out_q;

  // decode of the incoming byte
  logic [7:0]  b;
  logic        last;
  logic        is_op;
  logic [4:0]  len_b, len_cur;
  logic [4:0]  idx_inc, k;
  logic        stop_now, exec_now, draw_now, dec_done;
  logic [2:0]  rsn_stop, reason_n;
  logic [31:0] thick_word;
  logic [31:0] w0, w1, w2, w3;

  assign b       = in_data_i.data_byte;
  assign last    = in_data_i.stream_last;
  assign is_op   = (idx_q == 5'd0);
  assign len_b   = cmd_len(b);
  assign len_cur = cmd_len(opc_q);
  assign idx_inc = idx_q + 5'd1;
  assign k       = idx_q - 5'd1;
  assign thick_word = {b, opnd_q[2], opnd_q[1], opnd_q[0]};

  always_comb begin
    opc_n    = opc_q;
    idx_n    = idx_q;
    ops_n    = ops_q;
    color_n  = color_q;
    thick_n  = thick_q;
    stop_now = 1'b0;
    exec_now = 1'b0;
    rsn_stop = RSN_END;
    if (is_op) begin
      if (ops_q >= 8'(MAX_OPS)) begin
        stop_now = 1'b1;
        rsn_stop = RSN_OP_LIMIT;
      end else begin
        ops_n = ops_q + 8'd1;
        if (b == OP_END) begin
          stop_now = 1'b1;
          rsn_stop = RSN_END;
        end else if (len_b == LEN_UNKNOWN) begin
          stop_now = 1'b1;
          rsn_stop = RSN_UNKNOWN;
        end else if (len_b > LEN_SINGLE) begin
          opc_n = b;
          idx_n = 5'd1;
        end
      end
    end else begin
      idx_n = idx_inc;
      if (idx_inc >= len_cur) begin
        exec_now = 1'b1;
        idx_n    = 5'd0;
        if (opc_q == OP_COLOR || opc_q == OP_DITHER) begin
          // forward the byte when it is the color byte itself
          color_n = (k[3:0] == 4'd0) ? b[3:0] : opnd_q[0][3:0];
        end else if (opc_q == OP_THICK) begin
          if ($signed(thick_word) < $signed(32'sd1)) begin
            thick_n = THICK_RESET;
          end else if ($signed(thick_word) > $signed(32'(MAX_THICK))) begin
            thick_n = 3'(MAX_THICK);
          end else begin
            thick_n = thick_word[2:0];
          end
        end
      end
    end
  end

  always_comb begin
    draw_now = 1'b0;
    kind_n   = KIND_PIXEL;
    unique case (opc_q)
      OP_SHIFT, OP_POINT: begin
        draw_now = exec_now;
        kind_n   = KIND_PIXEL;
      end
      OP_LINE, OP_ARROW: begin
        draw_now = exec_now;
        kind_n   = KIND_LINE;
      end
      OP_RECT: begin
        draw_now = exec_now;
        kind_n   = KIND_RECT;
      end
      OP_CIRCLE: begin
        draw_now = exec_now;
        kind_n   = KIND_CIRCLE;
      end
      default: ;
    endcase
  end

  assign dec_done = !stopped_q && (stop_now || last);

  always_comb begin
    if (stop_now) begin
      reason_n = rsn_stop;
    end else if (idx_n != 5'd0 && !(opc_n == OP_FILL_A || opc_n == OP_FILL_B)) begin
      reason_n = RSN_TRUNC;
    end else begin
      reason_n = RSN_EXHAUSTED;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opc_q       <= OP_END;
      idx_q       <= '0;
      ops_q       <= '0;
      color_q     <= COLOR_WHITE;
      thick_q     <= THICK_RESET;
      stopped_q   <= 1'b0;
      anchor_x_q  <= '0;
      anchor_y_q  <= '0;
      is_line_q   <= 1'b0;
      done_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ANCHOR_X: anchor_x_q <= cfg_wdata_i;
          REG_ANCHOR_Y: anchor_y_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ctl_i.accept) begin
        if (last) begin
          opc_q     <= OP_END;
          idx_q     <= '0;
          ops_q     <= '0;
          color_q   <= COLOR_WHITE;
          thick_q   <= THICK_RESET;
          stopped_q <= 1'b0;
        end else if (!stopped_q) begin
          opc_q     <= opc_n;
          idx_q     <= idx_n;
          ops_q     <= ops_n;
          color_q   <= color_n;
          thick_q   <= thick_n;
          stopped_q <= stop_now;
        end
        is_line_q   <= (kind_n == KIND_LINE);
        done_pend_q <= dec_done;
      end
      if (ctl_i.draw_fire || ctl_i.done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operand bytes and emission context
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      if (!stopped_q && !is_op) begin
        opnd_q[k[3:0]] <= b;
      end
      kind_q     <= kind_n;
      reason_q   <= reason_n;
      em_color_q <= color_n;
      em_thick_q <= thick_q;
    end
  end

  assign w0 = {opnd_q[3],  opnd_q[2],  opnd_q[1],  opnd_q[0]};
  assign w1 = {opnd_q[7],  opnd_q[6],  opnd_q[5],  opnd_q[4]};
  assign w2 = {opnd_q[11], opnd_q[10], opnd_q[9],  opnd_q[8]};
  assign w3 = {opnd_q[15], opnd_q[14], opnd_q[13], opnd_q[12]};

  // anchoring, slope test and stroke stepping
  logic [32:0] abs_dx, abs_dy;
  logic [3:0]  offs4;
  logic [31:0] offs;
  logic        last_stroke;

  assign abs_dx = dx_q[32] ? (33'd0 - dx_q) : dx_q;
  assign abs_dy = dy_q[32] ? (33'd0 - dy_q) : dy_q;
  assign offs4  = {1'b0, stroke_q} - {2'b00, em_thick_q[2:1]};
  assign offs   = {{28{offs4[3]}}, offs4};
  assign last_stroke = (stroke_q == (em_thick_q - 3'd1));

  always_ff @(posedge clk_i) begin
    if (ctl_i.anch) begin
      x1_q     <= anchor_x_q + w0;
      y1_q     <= anchor_y_q + w1;
      x2_q     <= anchor_x_q + w2;
      y2_q     <= anchor_y_q + w3;
      stroke_q <= '0;
    end else if (ctl_i.draw_fire) begin
      stroke_q <= stroke_q + 3'd1;
    end
    if (ctl_i.diff) begin
      dx_q <= {x2_q[31], x2_q} - {x1_q[31], x1_q};
      dy_q <= {y2_q[31], y2_q} - {y1_q[31], y1_q};
    end
    if (ctl_i.hor) begin
      horiz_q <= (abs_dx >= abs_dy);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.draw_fire) begin
      out_q.kind        <= kind_q;
      out_q.color       <= em_color_q;
      out_q.stop_reason <= RSN_END;
      out_q.run_last    <= (!is_line_q || last_stroke) && !done_pend_q;
      unique case (kind_q)
        KIND_LINE: begin
          if (horiz_q) begin
            out_q.xa <= x1_q;
            out_q.ya <= y1_q + offs;
            out_q.xb <= x2_q;
            out_q.yb <= y2_q + offs;
          end else begin
            out_q.xa <= x1_q + offs;
            out_q.ya <= y1_q;
            out_q.xb <= x2_q + offs;
            out_q.yb <= y2_q;
          end
        end
        KIND_RECT: begin
          out_q.xa <= x1_q;
          out_q.ya <= y1_q;
          out_q.xb <= w2;
          out_q.yb <= w3;
        end
        KIND_CIRCLE: begin
          out_q.xa <= x1_q;
          out_q.ya <= y1_q;
          out_q.xb <= w2;
          out_q.yb <= '0;
        end
        default: begin
          out_q.xa <= x1_q;
          out_q.ya <= y1_q;
          out_q.xb <= '0;
          out_q.yb <= '0;
        end
      endcase
    end else if (ctl_i.done_fire) begin
      out_q.kind        <= KIND_DONE;
      out_q.xa          <= '0;
      out_q.ya          <= '0;
      out_q.xb          <= '0;
      out_q.yb          <= '0;
      out_q.color       <= em_color_q;
      out_q.stop_reason <= reason_q;
      out_q.run_last    <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.dec_draw    = !stopped_q && draw_now;
  assign sts_o.dec_done    = dec_done;
  assign sts_o.is_line     = is_line_q;
  assign sts_o.pend_done   = done_pend_q;
  assign sts_o.last_stroke = last_stroke;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// File: hdl/vector_sprite_command_parser_core.sv
// throughput: bytes that yield no result are accepted back to back
// pixel, rect or circle: closing byte accept, then anchor add, then result
// line or arrow: accept, anchor add, 33-bit difference and slope compare, then one
// result per stroke (thickness 1..5) through the single output register; a done
// transaction adds a result; every result waits until the output register is free
// reset: async active low; anchors 0, color white, thickness 1, parser awaits opcode
//
// top level of the sprite command parser
// depends on vscp_pkg, vscp_ctrl and vscp_dpath
module vector_sprite_command_parser_core
  import vscp_pkg::*;
#(
  parameter int MAX_OPS   = 200,
  parameter int MAX_THICK = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream byte channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  // drawing command channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  // anchor register write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  // command and status between the sequencer and the datapath
  ctl_t ctl;
  sts_t sts;

  // the sequencer holds in_ready high only while waiting for a byte; a byte whose
  // command completes a draw moves it through anchor and stroke steps, with slope steps for a line
  vscp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // the datapath parses the byte in its accept cycle, snapshots the color and
  // stop reason so a stream reset on the last byte does not disturb results
  // still to be delivered, and owns the output register
  vscp_dpath #(
    .MAX_OPS   (MAX_OPS),
    .MAX_THICK (MAX_THICK)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
